>>> src/cual_pkg.sv
// Shared types, codes and helper functions for the card identifier allow-list table.
`default_nettype none
package cual_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int ID_BYTES = 7;
  localparam int MASTER_ENTRIES = 2;
  localparam int ID_W = 56;
  localparam int LEN_W = 3;
  localparam int CFG_W = 64;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [2:0] {
    CMD_CHECK     = 3'd0,
    CMD_ADD       = 3'd1,
    CMD_ADD_NOMST = 3'd2,
    CMD_REMOVE    = 3'd3,
    CMD_CLEAR     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_MASTER    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TOK_CHECK  = 2'd0,
    TOK_ADD    = 2'd1,
    TOK_REMOVE = 2'd2
  } tok_op_e;

  typedef enum logic {
    CFG_MASTER_A = 1'b0,
    CFG_MASTER_B = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]       command;
    logic [ID_W-1:0]  card_id;
    logic [LEN_W-1:0] card_len;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   is_listed;
    logic                   is_master;
    logic [COUNT_OUT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
  } entry_t;

  typedef struct packed {
    tok_op_e          op;
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
    logic             found;
  } tok_t;

  function automatic logic [ID_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [ID_W-1:0] mask;
    mask = '0;
    for (int b = 0; b < ID_W / 8; b++) begin
      if ((b < int'(len)) && (b < ID_BYTES)) begin
        mask[b*8 +: 8] = 8'hFF;
      end
    end
    return mask;
  endfunction

  function automatic logic master_match(input logic [CFG_W-1:0] mreg,
                                        input logic [ID_W-1:0] id,
                                        input logic [LEN_W-1:0] len);
    logic len_ok;
    logic id_ok;
    len_ok = (mreg[7:0] == {5'd0, len});
    id_ok  = ((mreg[CFG_W-1:8] & byte_mask(len)) == id);
    return len_ok && id_ok;
  endfunction

endpackage
`default_nettype wire

>>> src/cual_cell.sv
// One table cell: holds one entry and passes the request token to its neighbor.
`default_nettype none
module cual_cell #(
  parameter int CELL_INDEX = 0,
  parameter int CW = 5
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [CW-1:0]   count_i,
  input  wire logic            tok_valid_i,
  input  wire cual_pkg::tok_t  tok_i,
  input  wire cual_pkg::entry_t next_entry_i,
  output logic                 tok_valid_o,
  output cual_pkg::tok_t       tok_o,
  output cual_pkg::entry_t     entry_o
);

  localparam logic [CW-1:0] Idx = CW'(CELL_INDEX);

  cual_pkg::entry_t entry_q;
  cual_pkg::tok_t   tok_q;
  logic             tok_valid_q;
  logic             match;
  logic             found;

  assign match = (Idx < count_i) && (entry_q.id == tok_i.id) && (entry_q.len == tok_i.len);
  assign found = tok_i.found | match;

  always_ff @(posedge clk_i) begin
    if (tok_valid_i) begin
      if ((tok_i.op == cual_pkg::TOK_REMOVE) && found) begin
        entry_q <= next_entry_i;
      end else if ((tok_i.op == cual_pkg::TOK_ADD) && (Idx == count_i)) begin
        entry_q.id  <= tok_i.id;
        entry_q.len <= tok_i.len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_valid_i) begin
      tok_q <= '{op: tok_i.op, id: tok_i.id, len: tok_i.len, found: found};
    end
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;
  assign entry_o     = entry_q;

endmodule
`default_nettype wire

>>> src/card_uid_allowlist_table_core.sv
// Top level of the card identifier allow-list table: command control and the cell chain.
// A request passes once through the chain, one cell per cycle; the result strobe
// is registered after the token leaves the last cell.
// One request at a time: busy is high until the result is shown, so a new request
// is taken only once the previous result is shown. The result is held for one cycle only,
// since the receiver cannot stall.
// Reset empties the table and clears both master card registers to zero.
`default_nettype none
module card_uid_allowlist_table_core #(
  parameter int TABLE_DEPTH = cual_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire cual_pkg::req_t            req_i,
  output logic                           rsp_valid_o,
  output cual_pkg::rsp_t                 rsp_o,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [cual_pkg::CFG_W-1:0] cfg_wdata_i
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  logic [cual_pkg::CFG_W-1:0] master_a_q;
  logic [cual_pkg::CFG_W-1:0] master_b_q;
  logic [CW-1:0]              count_q;
  logic [CW-1:0]              count_d;
  logic                       busy_q;
  logic                       tok_valid_q;
  cual_pkg::tok_t             tok_q;
  cual_pkg::cmd_e             cmd_q;
  logic                       master_q;
  logic                       rsp_valid_q;
  cual_pkg::rsp_t             rsp_q;
  cual_pkg::status_e          status_d;

  logic [cual_pkg::ID_W-1:0]  id_m;
  logic                       master_hit;
  cual_pkg::tok_op_e          op_d;
  logic                       accept;
  logic                       finish;

  logic                       tok_valid [TABLE_DEPTH+1];
  cual_pkg::tok_t             tok       [TABLE_DEPTH+1];
  cual_pkg::entry_t           entry     [TABLE_DEPTH];

  assign accept = start && !busy_q;
  assign id_m   = req_i.card_id & cual_pkg::byte_mask(req_i.card_len);
  assign master_hit =
      ((cual_pkg::MASTER_ENTRIES >= 1) && cual_pkg::master_match(master_a_q, id_m, req_i.card_len))
   || ((cual_pkg::MASTER_ENTRIES >= 2) && cual_pkg::master_match(master_b_q, id_m, req_i.card_len));

  always_comb begin
    unique case (req_i.command)
      cual_pkg::CMD_ADD:       op_d = cual_pkg::TOK_ADD;
      cual_pkg::CMD_ADD_NOMST: op_d = master_hit ? cual_pkg::TOK_CHECK : cual_pkg::TOK_ADD;
      cual_pkg::CMD_REMOVE:    op_d = cual_pkg::TOK_REMOVE;
      default:                 op_d = cual_pkg::TOK_CHECK;
    endcase
  end

  assign tok_valid[0] = tok_valid_q;
  assign tok[0]       = tok_q;
  assign finish       = tok_valid[TABLE_DEPTH];

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cual_cell #(
      .CELL_INDEX(i),
      .CW        (CW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .count_i     (count_q),
      .tok_valid_i (tok_valid[i]),
      .tok_i       (tok[i]),
      .next_entry_i(entry[(i == TABLE_DEPTH - 1) ? i : i + 1]),
      .tok_valid_o (tok_valid[i+1]),
      .tok_o       (tok[i+1]),
      .entry_o     (entry[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = cual_pkg::ST_DONE;
    case (cmd_q) inside
      cual_pkg::CMD_ADD_NOMST, cual_pkg::CMD_ADD: begin
        if ((cmd_q == cual_pkg::CMD_ADD_NOMST) && master_q) begin
          status_d = cual_pkg::ST_MASTER;
        end else if (count_q >= DepthC) begin
          status_d = cual_pkg::ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      cual_pkg::CMD_REMOVE: begin
        if (tok[TABLE_DEPTH].found) begin
          count_d = count_q - CW'(1);
        end else begin
          status_d = cual_pkg::ST_NOT_FOUND;
        end
      end
      cual_pkg::CMD_CLEAR: count_d = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_a_q  <= '0;
      master_b_q  <= '0;
      count_q     <= '0;
      busy_q      <= 1'b0;
      tok_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == cual_pkg::CFG_MASTER_A) begin
          master_a_q <= cfg_wdata_i;
        end else begin
          master_b_q <= cfg_wdata_i;
        end
      end
      tok_valid_q <= accept;
      rsp_valid_q <= finish;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      if (finish) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tok_q.op    <= op_d;
      tok_q.id    <= id_m;
      tok_q.len   <= req_i.card_len;
      tok_q.found <= 1'b0;
      cmd_q       <= cual_pkg::cmd_e'(req_i.command);
      master_q    <= master_hit;
    end
    if (finish) begin
      rsp_q.status      <= status_d;
      rsp_q.is_listed   <= tok[TABLE_DEPTH].found;
      rsp_q.is_master   <= master_q;
      rsp_q.entry_count <= cual_pkg::COUNT_OUT_W'(count_d);
    end
  end

  assign busy        = busy_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
`default_nettype wire
